@@ hw/rtl/ipv4_dotted_quad_parser_core_assert.svh @@
// Assertion macros for the parser RTL.
`ifndef IPV4_DOTTED_QUAD_PARSER_CORE_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPV4DQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPV4DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ipv4dq_pkg.sv @@
// Types and constants for the dotted-quad parser.
package ipv4dq_pkg;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [11:0] OCTET_MAX = 12'd255;
    localparam logic [1:0] LAST_OCTET = 2'd3;
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [1:0]  octet_index;
        logic [1:0]  digit_count;
        logic [7:0]  octet_value;
        logic [23:0] upper_octets;
        logic        error_seen;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic [31:0] address;
        logic        ok;
    } parse_result_t;

    localparam parse_state_t STATE_CLEAR = '{
        octet_index:  2'd0,
        digit_count:  2'd0,
        octet_value:  8'd0,
        upper_octets: 24'd0,
        error_seen:   1'b0
    };

endpackage

@@ hw/rtl/ipv4dq_step.sv @@
// Per-character next-state and result logic of the dotted-quad parser.
module ipv4dq_step
    import ipv4dq_pkg::*;
(
    input  parse_state_t  state,
    input  logic [7:0]    char_code,
    output parse_state_t  state_next,
    output parse_result_t result
);

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] octet_acc;
    logic        end_ok;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit     = char_code[3:0];
    // value * 10 + digit as (value << 3) + (value << 1) + digit
    assign octet_acc = {1'b0, state.octet_value, 3'b000}
                     + {3'b000, state.octet_value, 1'b0}
                     + {8'd0, digit};
    assign end_ok    = !state.error_seen && (state.octet_index == LAST_OCTET)
                     && (state.digit_count != 2'd0);

    always_comb
    begin
        state_next     = state;
        result.emit    = 1'b0;
        result.ok      = end_ok;
        result.address = end_ok ? {state.upper_octets, state.octet_value} : 32'd0;

        if (char_code == CHAR_NUL)
        begin
            result.emit = 1'b1;
            state_next  = STATE_CLEAR;
        end
        else if (state.error_seen)
        begin
            // drop characters until the terminator
            state_next = state;
        end
        else if (is_digit)
        begin
            if (state.digit_count == MAX_DIGITS || octet_acc > OCTET_MAX)
            begin
                state_next.error_seen = 1'b1;
            end
            else
            begin
                state_next.octet_value = octet_acc[7:0];
                state_next.digit_count = state.digit_count + 2'd1;
            end
        end
        else if (char_code == CHAR_DOT)
        begin
            if (state.digit_count == 2'd0 || state.octet_index == LAST_OCTET)
            begin
                state_next.error_seen = 1'b1;
            end
            else
            begin
                state_next.upper_octets = {state.upper_octets[15:0], state.octet_value};
                state_next.octet_index  = state.octet_index + 2'd1;
                state_next.digit_count  = 2'd0;
                state_next.octet_value  = 8'd0;
            end
        end
        else
        begin
            state_next.error_seen = 1'b1;
        end
    end

endmodule

@@ hw/rtl/ipv4_dotted_quad_parser_core.sv @@
// Top level of the streaming IPv4 dotted-quad parser.
//
//  Channel  Direction  Handshake           Payload
//  in       sink       in_valid/in_stall   char_code[7:0]
//  out      source     out_valid/out_stall address[31:0], valid_res
//
// One character is taken per cycle while in_stall is low; the parse state register updates on each beat.
// The NUL beat loads the output register, which shows the result the next cycle.
// Non-NUL beats are taken even while a result waits; a NUL beat stalls only while
// the output register is full and stalled.
// Reset (rst_n low) clears the parse state and the output valid.
`include "ipv4_dotted_quad_parser_core_assert.svh"

module ipv4_dotted_quad_parser_core
    import ipv4dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] address,
    output logic        valid_res
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   address_reg;
    logic          valid_res_reg;
    logic          in_beat;
    logic          load_result;

    ipv4dq_step u_step (
        .state      (state_reg),
        .char_code  (char_code),
        .state_next (state_next),
        .result     (result)
    );

    // hold a terminator only when the finished result cannot leave
    assign in_stall    = out_valid_reg && out_stall && (char_code == CHAR_NUL);
    assign in_beat     = in_valid && !in_stall;
    assign load_result = in_beat && result.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            address_reg   <= result.address;
            valid_res_reg <= result.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign valid_res = valid_res_reg;

    `IPV4DQ_ASSERT_NOW(a_invalid_addr_zero, clk, rst_n, out_valid && !valid_res, address == 32'd0, "invalid result carries a nonzero address")
    `IPV4DQ_ASSERT_NOW(a_empty_octet_zero, clk, rst_n, state_reg.digit_count == 2'd0, state_reg.octet_value == 8'd0, "octet value without digits")
    `IPV4DQ_ASSERT_NOW(a_first_octet_clean, clk, rst_n, state_reg.octet_index == 2'd0, state_reg.upper_octets == 24'd0, "upper octets set before first dot")
    `IPV4DQ_ASSERT_NEXT(a_nul_clears, clk, rst_n, in_valid && !in_stall && char_code == CHAR_NUL, out_valid && state_reg == STATE_CLEAR, "terminator did not emit and clear")

endmodule
